>>> src/sdf_pkg.sv
// Shared types and constants for the set difference filter.
// No dependencies; every other file of the block refers to this package.
package sdf_pkg;

    // Widths of the stream fields.
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Codes of the action field.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    // Control word that travels down the chain beside each value.
    // flag: on a probe, an entry matched; on a load, the value was stored.
    typedef struct packed {
        logic valid;
        logic probe;
        logic first;
        logic flag;
    } t_ctrl;

endpackage

>>> src/sdf_if.sv
// Stream interfaces of the set difference filter: input items and results.
// Depends on sdf_pkg for the field widths.
interface sdf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic                          first_entry;
    logic signed [sdf_pkg::VALUE_W-1:0] value;

    modport source (output valid, output action, output first_entry, output value,
                    input ready);
    modport sink   (input valid, input action, input first_entry, input value,
                    output ready);
endinterface

interface sdf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sdf_pkg::VALUE_W-1:0] value_res;
    logic        [sdf_pkg::COUNT_W-1:0] miss_count;

    modport source (output valid, output value_res, output miss_count, input ready);
    modport sink   (input valid, input value_res, input miss_count, output ready);
endinterface

>>> src/sdf_cell.sv
// One cell of the filter chain: holds a single table entry and its occupancy.
// Depends on sdf_pkg for the control word type and action codes.
module sdf_cell #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  sdf_pkg::t_ctrl i_ctrl,
    input  logic [W-1:0]   i_value,
    output sdf_pkg::t_ctrl o_ctrl,
    output logic [W-1:0]   o_value
);

    logic           r_used;
    logic           n_used;
    logic [W-1:0]   r_entry;
    logic           w_store;
    sdf_pkg::t_ctrl r_ctrl;
    sdf_pkg::t_ctrl n_ctrl;
    logic [W-1:0]   r_value;

    // Work on the item passing through: a load takes the first free cell it
    // meets, a first load empties each cell it passes, and a probe collects hits.
    always_comb begin
        n_used  = r_used;
        n_ctrl  = i_ctrl;
        w_store = 1'b0;
        if (i_ctrl.valid) begin
            if (i_ctrl.probe == sdf_pkg::ACT_PROBE) begin
                n_ctrl.flag = i_ctrl.flag | (r_used && (r_entry == i_value));
            end else begin
                if (i_ctrl.first) begin
                    n_used = 1'b0;
                end
                if (!i_ctrl.flag && (i_ctrl.first || !r_used)) begin
                    w_store     = 1'b1;
                    n_used      = 1'b1;
                    n_ctrl.flag = 1'b1;
                end
            end
        end
    end

    // Control state of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_ctrl <= '0;
        end else if (i_adv) begin
            r_used <= n_used;
            r_ctrl <= n_ctrl;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_value <= i_value;
            if (w_store) begin
                r_entry <= i_value;
            end
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_value = r_value;

    // An occupied cell stays occupied unless a first load passes it.
    a_used_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used && !(i_adv && i_ctrl.valid && (i_ctrl.probe == sdf_pkg::ACT_LOAD)
                     && i_ctrl.first)) |=> r_used)
        else $error("cell lost its entry without a first load");

endmodule

>>> src/sdf_tail.sv
// End of the filter chain: keeps the saturating miss count and the result register.
// Depends on sdf_pkg for the control word type, widths and action codes.
module sdf_tail #(
    parameter int W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  sdf_pkg::t_ctrl                i_ctrl,
    input  logic [W-1:0]                  i_value,
    output logic                          o_valid,
    output logic [sdf_pkg::VALUE_W-1:0]   o_value,
    output logic [sdf_pkg::COUNT_W-1:0]   o_count
);

    logic                        r_ovalid;
    logic                        n_ovalid;
    logic [sdf_pkg::COUNT_W-1:0] r_count;
    logic [sdf_pkg::COUNT_W-1:0] n_count;
    logic [sdf_pkg::VALUE_W-1:0] r_value;
    logic                        w_miss;
    logic                        w_clear;

    assign w_miss  = i_ctrl.valid && (i_ctrl.probe == sdf_pkg::ACT_PROBE) && !i_ctrl.flag;
    assign w_clear = i_ctrl.valid && (i_ctrl.probe == sdf_pkg::ACT_LOAD) && i_ctrl.first;

    // Next count and result valid when the chain advances.
    always_comb begin
        n_count  = r_count;
        n_ovalid = r_ovalid;
        if (i_adv) begin
            n_ovalid = w_miss;
            if (w_clear) begin
                n_count = '0;
            end else if (w_miss && (r_count != sdf_pkg::COUNT_MAX)) begin
                n_count = r_count + sdf_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_count  <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            r_count  <= n_count;
        end
    end

    // Result value, zero extended from the kept width.
    always_ff @(posedge i_clk) begin
        if (i_adv && w_miss) begin
            r_value <= sdf_pkg::VALUE_W'(i_value);
        end
    end

    assign o_valid = r_ovalid;
    assign o_value = r_value;
    assign o_count = r_count;

    // A shown result always carries a count of at least one.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_count != '0))
        else $error("result shown with zero miss count");

    // A load or a hit that reaches the end produces no result.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_ctrl.valid && !w_miss) |=> !r_ovalid)
        else $error("result produced by a non-missing item");

    // The count stays saturated until a first load clears it.
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == sdf_pkg::COUNT_MAX) && !(i_adv && w_clear))
        |=> (r_count == sdf_pkg::COUNT_MAX))
        else $error("saturated miss count changed");

endmodule

>>> src/set_difference_filter.sv
// Set difference filter: a chain of DEPTH cells, one table entry per cell.
// Throughput: one item per cycle; a held result stalls the whole chain.
// Reset clears all occupancy flags, the pipeline valids and the miss count;
// entries themselves are not cleared.
module set_difference_filter #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdf_in_if.sink      i_in,
    sdf_out_if.source   o_out
);

    localparam int W = (VALUE_BITS < sdf_pkg::VALUE_W) ? VALUE_BITS : sdf_pkg::VALUE_W;

    sdf_pkg::t_ctrl w_ctrl  [DEPTH+1];
    logic [W-1:0]   w_value [DEPTH+1];
    logic           w_adv;

    // The chain moves whenever the result register is free or being taken.
    assign w_adv      = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // Item entering the first cell.
    always_comb begin
        w_ctrl[0].valid = i_in.valid;
        w_ctrl[0].probe = i_in.action;
        w_ctrl[0].first = i_in.first_entry;
        w_ctrl[0].flag  = 1'b0;
        w_value[0]      = i_in.value[W-1:0];
    end

    // Row of entry cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sdf_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctrl  (w_ctrl[g]),
            .i_value (w_value[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_value (w_value[g+1])
        );
    end

    // Miss counting and result register.
    sdf_tail #(.W(W)) u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctrl  (w_ctrl[DEPTH]),
        .i_value (w_value[DEPTH]),
        .o_valid (o_out.valid),
        .o_value (o_out.value_res),
        .o_count (o_out.miss_count)
    );

endmodule

>>> sim/sdf_miss_checker.sv
`timescale 1ns / 1ps
// Checker for the set difference filter: predicts the misses and compares results.
// Depends on sdf_pkg and on the stream interfaces in sdf_if.sv.
module sdf_miss_checker #(
    parameter int DEPTH      = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sdf_in_if     i_in,
    sdf_out_if    i_out,
    output int    o_fail_count,
    output int    o_pending
);

    // One expected miss: the probe value and the count it should carry.
    typedef struct packed {
        logic [sdf_pkg::VALUE_W-1:0] value;
        logic [sdf_pkg::COUNT_W-1:0] count;
    } t_miss;

    localparam logic [sdf_pkg::VALUE_W-1:0] KEEP_MASK =
        {sdf_pkg::VALUE_W{1'b1}} >> (sdf_pkg::VALUE_W - VALUE_BITS);

    logic [sdf_pkg::VALUE_W-1:0] excl_table [DEPTH];
    int                          excl_count;
    logic [sdf_pkg::COUNT_W-1:0] miss_total;
    t_miss                       pending_misses [$];
    int                          fails = 0;

    // Apply one accepted item to the predicted table and queue any miss it causes.
    task automatic filter_item(input logic act, input logic first,
                               input logic [sdf_pkg::VALUE_W-1:0] raw);
        logic [sdf_pkg::VALUE_W-1:0] key;
        logic                        hit;
        t_miss                       miss;
        int                          k;
        key = raw & KEEP_MASK;
        if (act == sdf_pkg::ACT_LOAD) begin
            if (first) begin
                excl_count = 0;
                miss_total = '0;
            end
            // A load on a full table is dropped.
            if (excl_count < DEPTH) begin
                excl_table[excl_count] = key;
                excl_count++;
            end
        end else begin
            hit = 1'b0;
            for (k = 0; k < excl_count; k++) begin
                if (excl_table[k] == key) hit = 1'b1;
            end
            if (!hit) begin
                if (miss_total != sdf_pkg::COUNT_MAX) miss_total++;
                miss.value = key;
                miss.count = miss_total;
                pending_misses.push_back(miss);
            end
        end
    endtask

    // Compare result transfers first, then fold in the input transfer of the same edge.
    always @(posedge i_clk) begin
        t_miss want;
        if (!i_rst_n) begin
            excl_count = 0;
            miss_total = '0;
            pending_misses.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_misses.size() == 0) begin
                    $error("unexpected result: value_res %h, miss_count %0d",
                           i_out.value_res, i_out.miss_count);
                    fails++;
                end else begin
                    want = pending_misses.pop_front();
                    if (i_out.value_res !== want.value) begin
                        $error("value_res: expected %h, actual %h", want.value,
                               i_out.value_res);
                        fails++;
                    end
                    if (i_out.miss_count !== want.count) begin
                        $error("miss_count: expected %0d, actual %0d", want.count,
                               i_out.miss_count);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                filter_item(i_in.action, i_in.first_entry, i_in.value);
            end
        end
        o_pending    <= pending_misses.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the set difference filter testbench: clock, reset, stimulus and verdict.
// Depends on sdf_pkg, sdf_if.sv, the filter RTL and sim/sdf_miss_checker.sv.
module testbench;

    localparam int TABLE_DEPTH = 64;
    localparam int RAND_ITEMS  = 2000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic quiet = 1'b0;
    int   fail_count;
    int   pending;
    int   items_sent = 0;
    logic [sdf_pkg::VALUE_W-1:0] loaded_vals [$];

    sdf_in_if  in_ch ();
    sdf_out_if out_ch ();

    set_difference_filter #(
        .DEPTH      (TABLE_DEPTH),
        .VALUE_BITS (sdf_pkg::VALUE_W)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sdf_miss_checker #(
        .DEPTH      (TABLE_DEPTH),
        .VALUE_BITS (sdf_pkg::VALUE_W)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    // The result side stalls about a third of the cycles, except in the quiet stretch.
    always @(posedge clk) begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= 33);
    end

    // Values biased toward extremes and a small range so that probes hit often.
    function automatic logic [sdf_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: rand_value = $urandom_range(0, 8) - 4;
            1: case ($urandom_range(0, 3))
                   0: rand_value = 32'h8000_0000;
                   1: rand_value = 32'h7FFF_FFFF;
                   2: rand_value = 32'h0000_0000;
                   default: rand_value = 32'hFFFF_FFFF;
               endcase
            default: rand_value = $urandom;
        endcase
    endfunction

    // Present one item, idling at random first, and hold it until its transfer.
    task automatic send_item(input logic act, input logic first,
                             input logic [sdf_pkg::VALUE_W-1:0] val);
        while (!quiet && $urandom_range(0, 99) < 33) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.first_entry <= first;
        in_ch.value       <= val;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic load_entry(input logic first, input logic [sdf_pkg::VALUE_W-1:0] val);
        if (first) loaded_vals.delete();
        loaded_vals.push_back(val);
        send_item(sdf_pkg::ACT_LOAD, first, val);
    endtask

    // Stop sending and wait until every predicted miss has come out.
    task automatic drain_misses();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    initial begin : stimulus
        int unsigned                 nload;
        int unsigned                 nprobe;
        int unsigned                 k;
        logic                        mid_drain;
        logic [sdf_pkg::VALUE_W-1:0] v;
        mid_drain = 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= sdf_pkg::ACT_LOAD;
        in_ch.first_entry <= 1'b0;
        in_ch.value       <= '0;
        rst_n             <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: every probe passes, first_entry has no effect on a probe.
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h0000_0000);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h7FFF_FFFF);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h8000_0000);
        send_item(sdf_pkg::ACT_PROBE, 1'b1, 32'hFFFF_FFFF);
        // Fill with extremes; the first load also clears the count.
        load_entry(1'b1, 32'h8000_0000);
        load_entry(1'b0, 32'h7FFF_FFFF);
        load_entry(1'b0, 32'h0000_0000);
        load_entry(1'b0, 32'hFFFF_FFFF);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h8000_0000);
        send_item(sdf_pkg::ACT_PROBE, 1'b1, 32'h7FFF_FFFF);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h0000_0000);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'hFFFF_FFFF);
        // Duplicate misses are each passed on.
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h0000_0001);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h0000_0001);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'hFFFF_FFFE);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h5555_AAAA);
        // A new table drops the old entries.
        load_entry(1'b1, 32'h0000_0005);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h0000_0000);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h0000_0005);
        send_item(sdf_pkg::ACT_PROBE, 1'b0, 32'h8000_0000);
        drain_misses();

        // Random part: mostly complete table sequences, some noise.
        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            quiet = (items_sent >= 900) && (items_sent < 1200);
            if (!mid_drain && items_sent >= 1500) begin
                mid_drain = 1'b1;
                drain_misses();
            end
            if ($urandom_range(0, 9) < 8) begin
                // Some sequences overflow the table to exercise the full case.
                nload = ($urandom_range(0, 5) == 0) ? $urandom_range(TABLE_DEPTH - 4,
                        TABLE_DEPTH + 8) : $urandom_range(1, 12);
                load_entry(1'b1, rand_value());
                for (k = 1; k < nload; k++) load_entry(1'b0, rand_value());
                nprobe = $urandom_range(1, 20);
                for (k = 0; k < nprobe; k++) begin
                    case ($urandom_range(0, 3))
                        0, 1: v = loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
                        2: v = rand_value();
                        default: v = loaded_vals[$urandom_range(0, loaded_vals.size() - 1)]
                                     ^ (32'h1 << $urandom_range(0, sdf_pkg::VALUE_W - 1));
                    endcase
                    send_item(sdf_pkg::ACT_PROBE, 1'($urandom_range(0, 1)), v);
                end
            end else begin
                nload = $urandom_range(1, 8);
                for (k = 0; k < nload; k++) begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              rand_value());
                end
            end
        end
        quiet = 1'b0;

        // Let the chain empty out, then give the verdict.
        drain_misses();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0) begin
            $display("set_difference_filter: match");
        end else begin
            $display("set_difference_filter: mismatch");
        end
        $finish;
    end

    // Watchdog in case the block stops moving.
    initial begin : watchdog
        #4ms;
        $display("set_difference_filter: mismatch");
        $finish;
    end

endmodule

>>> sim.f
src/sdf_pkg.sv
src/sdf_if.sv
src/sdf_cell.sv
src/sdf_tail.sv
src/set_difference_filter.sv
sim/sdf_miss_checker.sv
sim/testbench.sv
